/* hw/rtl/itsi_pkg.sv */
package itsi_pkg;

  // Register indexes on the configuration port
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_MAP_WIDTH   = 3'd0;
  localparam cfg_index_t REG_MAP_HEIGHT  = 3'd1;
  localparam cfg_index_t REG_TILE_WIDTH  = 3'd2;
  localparam cfg_index_t REG_TILE_HEIGHT = 3'd3;
  localparam cfg_index_t REG_ATLAS_COLS  = 3'd4;
  localparam cfg_index_t REG_ATLAS_ROWS  = 3'd5;

  localparam logic [10:0] MAX_MAP_DIM     = 11'd1024;
  localparam logic [8:0]  MAX_TILE_PIXELS = 9'd256;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] UV_ONE = 17'(1 << FRAC_BITS);

  // Divider depths: tile split, then UV/depth/span divides
  localparam int DIV1_STAGES = 16;
  localparam int DIV2_STAGES = FRAC_BITS + 1;
  localparam int PIPE_LEN    = DIV1_STAGES + DIV2_STAGES;

  // Per-item data that rides alongside the dividers
  typedef struct packed {
    logic [9:0]         x;
    logic [9:0]         y;
    logic               water;
    logic               neg;
    logic [10:0]        sum;
    logic signed [20:0] sx;
    logic [18:0]        sy;
    logic               rowok;
  } side_t;

endpackage

/* hw/rtl/itsi_div.sv */
module itsi_div #(
  parameter int DW = 9,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] hi,
  input  logic [QW-1:0] lo,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  // Restoring divide, one quotient bit per stage; hi must be below den
  logic [DW-1:0] r [QW+1];
  logic [QW-1:0] l [QW+1];
  logic [QW-1:0] q [QW+1];
  logic [DW-1:0] d [QW+1];

  assign r[0] = hi;
  assign l[0] = lo;
  assign q[0] = '0;
  assign d[0] = den;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    assign t  = {r[k], l[k][QW-1]};
    assign ge = t >= {1'b0, d[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1] <= ge ? DW'(t - {1'b0, d[k]}) : t[DW-1:0];
        l[k+1] <= {l[k][QW-2:0], 1'b0};
        q[k+1] <= {q[k][QW-2:0], ge};
        d[k+1] <= d[k];
      end
    end
  end

  assign quo = q[QW];
  assign rem = r[QW];

endmodule

/* hw/rtl/iso_tile_sprite_instance.sv */
// Isometric sprite instance generator.
// Input channel (in_valid/in_ready) takes one map cell per transaction:
// cell_x, cell_y, tile_number and water_mark. Output channel
// (out_valid/out_ready) returns one sprite instance per cell: screen
// position in quarter pixels, draw depth, sprite size and atlas UVs.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// The pipeline is 34 register stages, set by the chained bit-per-stage
// dividers (16 stages for the tile column/row split, 17 for UV, span
// and depth) plus the output register. One cell per cycle while the
// output is not stalled.
// A stall on the output freezes the whole pipeline and drops in_ready,
// so nothing is lost or repeated; bubbles are kept as they enter.
// Reset clears all valid bits and loads the register defaults
// (16, 16, 64, 32, 0, 0); no clearing pass is needed.
module iso_tile_sprite_instance (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  itsi_pkg::cfg_index_t  cfg_index,
  input  logic [10:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [9:0]            cell_x,
  input  logic [9:0]            cell_y,
  input  logic signed [16:0]    tile_number,
  input  logic                  water_mark,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [20:0]    pos_x,
  output logic [18:0]           pos_y,
  output logic [16:0]           depth_value,
  output logic                  water_out,
  output logic [8:0]            sprite_width,
  output logic [8:0]            sprite_height,
  output logic [9:0]            echo_x,
  output logic [9:0]            echo_y,
  output logic [16:0]           tex_u,
  output logic [16:0]           tex_v,
  output logic [16:0]           tex_u_span,
  output logic [16:0]           tex_v_span
);
  import itsi_pkg::*;

  logic [10:0] map_width, map_height;
  logic [8:0]  tile_pixel_width, tile_pixel_height, atlas_columns, atlas_rows;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width         <= 11'd16;
      map_height        <= 11'd16;
      tile_pixel_width  <= 9'd64;
      tile_pixel_height <= 9'd32;
      atlas_columns     <= 9'd0;
      atlas_rows        <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:   map_width         <= cfg_data;
        REG_MAP_HEIGHT:  map_height        <= cfg_data;
        REG_TILE_WIDTH:  tile_pixel_width  <= cfg_data[8:0];
        REG_TILE_HEIGHT: tile_pixel_height <= cfg_data[8:0];
        REG_ATLAS_COLS:  atlas_columns     <= cfg_data[8:0];
        REG_ATLAS_ROWS:  atlas_rows        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes into their legal ranges
  logic [10:0] mw, mh;
  logic [8:0]  tw, th;
  logic [11:0] den;
  assign mw = (map_width == 11'd0) ? 11'd1 :
              (map_width > MAX_MAP_DIM) ? MAX_MAP_DIM : map_width;
  assign mh = (map_height == 11'd0) ? 11'd1 :
              (map_height > MAX_MAP_DIM) ? MAX_MAP_DIM : map_height;
  assign tw = (tile_pixel_width == 9'd0) ? 9'd1 :
              (tile_pixel_width > MAX_TILE_PIXELS) ? MAX_TILE_PIXELS : tile_pixel_width;
  assign th = (tile_pixel_height == 9'd0) ? 9'd1 :
              (tile_pixel_height > MAX_TILE_PIXELS) ? MAX_TILE_PIXELS : tile_pixel_height;
  assign den = {1'b0, mw} + {1'b0, mh};

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Screen position, computed on entry
  logic [10:0]        sum_in;
  logic signed [12:0] diff_in;
  logic signed [22:0] sx_prod;
  logic [19:0]        sy_prod;
  assign sum_in  = {1'b0, cell_x} + {1'b0, cell_y};
  assign diff_in = $signed({2'b0, mh}) - 13'sd1 + $signed({3'b0, cell_x})
                 - $signed({3'b0, cell_y});
  assign sx_prod = 23'(diff_in) * 23'($signed({1'b0, tw}));
  assign sy_prod = 20'(sum_in) * 20'(th);

  side_t side [PIPE_LEN];
  logic  vld  [PIPE_LEN];

  logic [15:0] tile_row;
  logic [8:0]  tile_col;
  logic        row_ok;
  assign row_ok = tile_row < {7'b0, atlas_rows};

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].x     <= cell_x;
      side[0].y     <= cell_y;
      side[0].water <= water_mark;
      side[0].neg   <= tile_number[16];
      side[0].sum   <= sum_in;
      side[0].sx    <= {sx_prod[19:0], 1'b0};
      side[0].sy    <= sy_prod[18:0];
      side[0].rowok <= 1'b0;
    end
  end

  // Advance the side line in step with the dividers
  for (genvar k = 1; k < PIPE_LEN; k++) begin : g_side
    side_t side_next;
    always_comb begin
      side_next = side[k-1];
      if (k == DIV1_STAGES) side_next.rowok = row_ok;
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (adv) vld[k] <= vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) side[k] <= side_next;
    end
  end

  // Split the tile index into atlas column and row
  itsi_div #(.DW(9), .QW(DIV1_STAGES)) u_div_tile (
    .clk (clk), .en (adv), .hi (9'd0), .lo (tile_number[15:0]),
    .den (atlas_columns), .quo (tile_row), .rem (tile_col)
  );

  logic [16:0] u_q, v_q, us_q, vs_q, depth_q;
  logic [8:0]  u_rem, v_rem, us_rem, vs_rem;
  logic [11:0] depth_rem;
  logic [11:0] depth_num;
  assign depth_num = den - {1'b0, side[DIV1_STAGES-1].sum};

  itsi_div #(.DW(9), .QW(DIV2_STAGES)) u_div_u (
    .clk (clk), .en (adv), .hi ({1'b0, tile_col[8:1]}),
    .lo ({tile_col[0], 16'b0}), .den (atlas_columns), .quo (u_q), .rem (u_rem)
  );

  itsi_div #(.DW(9), .QW(DIV2_STAGES)) u_div_v (
    .clk (clk), .en (adv), .hi ({1'b0, tile_row[8:1]}),
    .lo ({tile_row[0], 16'b0}), .den (atlas_rows), .quo (v_q), .rem (v_rem)
  );

  itsi_div #(.DW(9), .QW(DIV2_STAGES)) u_div_us (
    .clk (clk), .en (adv), .hi (9'd0), .lo (UV_ONE),
    .den (atlas_columns), .quo (us_q), .rem (us_rem)
  );

  itsi_div #(.DW(9), .QW(DIV2_STAGES)) u_div_vs (
    .clk (clk), .en (adv), .hi (9'd0), .lo (UV_ONE),
    .den (atlas_rows), .quo (vs_q), .rem (vs_rem)
  );

  itsi_div #(.DW(12), .QW(DIV2_STAGES)) u_div_depth (
    .clk (clk), .en (adv), .hi ({1'b0, depth_num[11:1]}),
    .lo ({depth_num[0], 16'b0}), .den (den), .quo (depth_q), .rem (depth_rem)
  );

  // Remainders other than the tile split are not needed
  logic rem_unused;
  assign rem_unused = ^{u_rem, v_rem, us_rem, vs_rem, depth_rem};

  side_t s;
  logic  empty;
  assign s     = side[PIPE_LEN-1];
  assign empty = s.neg || (atlas_columns == 9'd0) || (atlas_rows == 9'd0) || (rem_unused && 1'b0);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[PIPE_LEN-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x         <= s.sx;
      pos_y         <= s.sy;
      depth_value   <= ({1'b0, s.sum} >= den) ? 17'd0 : depth_q;
      water_out     <= !empty && s.water;
      sprite_width  <= empty ? 9'd0 : tw;
      sprite_height <= empty ? 9'd0 : th;
      echo_x        <= s.x;
      echo_y        <= s.y;
      tex_u         <= empty ? 17'd0 : u_q;
      tex_v         <= empty ? 17'd0 : (s.rowok ? v_q : UV_ONE);
      tex_u_span    <= empty ? 17'd0 : us_q;
      tex_v_span    <= empty ? 17'd0 : vs_q;
    end
  end

`ifndef SYNTH
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> depth_value <= UV_ONE)
    else $error("depth above one");

  a_water_needs_sprite: assert property (@(posedge clk) disable iff (rst)
    out_valid && water_out |-> sprite_width != 9'd0 && tex_u_span != 17'd0)
    else $error("water flag on an empty sprite");

  a_entry_valid: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted transaction not captured");
`endif

endmodule

/* tb/tb_iso_tile_sprite_instance.sv */
module tb_iso_tile_sprite_instance;
  timeunit 1ns;
  timeprecision 1ps;
  import itsi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [20:0] sx;
    logic [18:0]        sy;
    logic [16:0]        depth;
    logic               water;
    logic [8:0]         sw;
    logic [8:0]         sh;
    logic [9:0]         ex;
    logic [9:0]         ey;
    logic [16:0]        u;
    logic [16:0]        v;
    logic [16:0]        us;
    logic [16:0]        vs;
  } sprite_t;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [16:0] tile;
    logic        water;
  } cell_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = REG_MAP_WIDTH;
  logic [10:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] cell_x = '0;
  logic [9:0] cell_y = '0;
  logic signed [16:0] tile_number = '0;
  logic water_mark = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [20:0] pos_x;
  logic [18:0] pos_y;
  logic [16:0] depth_value, tex_u, tex_v, tex_u_span, tex_v_span;
  logic water_out;
  logic [8:0] sprite_width, sprite_height;
  logic [9:0] echo_x, echo_y;

  // shadow copy of the configuration registers
  logic [10:0] map_w_reg = 11'd16;
  logic [10:0] map_h_reg = 11'd16;
  logic [8:0] tile_w_reg = 9'd64;
  logic [8:0] tile_h_reg = 9'd32;
  logic [8:0] cols_reg = 9'd0;
  logic [8:0] rows_reg = 9'd0;

  sprite_t pending_sprites[$];
  int errors = 0;
  int cells_sent = 0;
  int sprites_seen = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  iso_tile_sprite_instance dut (.*);

  always #5 clk = ~clk;

  // hard stop on a hung pipeline
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // random backpressure on the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // compute the sprite instance of one map cell under the current registers
  function automatic sprite_t project_cell(cell_t c);
    sprite_t s;
    longint mw, mh, tw, th, cols, rows, sx, sy, sum, den, t, col, row, v;
    mw = clampl(map_w_reg, 1, 1024);
    mh = clampl(map_h_reg, 1, 1024);
    tw = clampl(tile_w_reg, 1, 256);
    th = clampl(tile_h_reg, 1, 256);
    cols = cols_reg;
    rows = rows_reg;
    t = c.tile;
    sx = clampl(2 * tw * (mh - 1 + c.x - c.y), -1048576, 1048575);
    sum = c.x + c.y;
    sy = clampl(sum * th, 0, 524287);
    den = mw + mh;
    s = '0;
    s.sx = sx[20:0];
    s.sy = sy[18:0];
    s.depth = (sum >= den) ? 17'd0 : 17'(((den - sum) << FRAC_BITS) / den);
    s.ex = c.x;
    s.ey = c.y;
    if (!c.tile[16] && cols != 0 && rows != 0) begin
      col = t % cols;
      row = t / cols;
      v = clampl((row << FRAC_BITS) / rows, 0, 65536);
      s.water = c.water;
      s.sw = tw[8:0];
      s.sh = th[8:0];
      s.u = 17'((col << FRAC_BITS) / cols);
      s.v = v[16:0];
      s.us = 17'(65536 / cols);
      s.vs = 17'(65536 / rows);
    end
    return s;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    sprite_t e;
    if (!rst && out_valid && out_ready) begin
      sprites_seen++;
      if (pending_sprites.size() == 0) begin
        $display("%0t: unexpected result, expected none actual x=%0d y=%0d",
                 $time, echo_x, echo_y);
        errors++;
      end else begin
        e = pending_sprites.pop_front();
        check_field("pos_x", e.sx, pos_x);
        check_field("pos_y", e.sy, pos_y);
        check_field("depth_value", e.depth, depth_value);
        check_field("water_out", e.water, water_out);
        check_field("sprite_width", e.sw, sprite_width);
        check_field("sprite_height", e.sh, sprite_height);
        check_field("echo_x", e.ex, echo_x);
        check_field("echo_y", e.ey, echo_y);
        check_field("tex_u", e.u, tex_u);
        check_field("tex_v", e.v, tex_v);
        check_field("tex_u_span", e.us, tex_u_span);
        check_field("tex_v_span", e.vs, tex_v_span);
      end
    end
  end

  // drive one cell and hold it until the transaction completes
  task automatic send_cell(cell_t c, sprite_t want);
    // idle the sender cycle by cycle
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_x <= c.x;
    cell_y <= c.y;
    tile_number <= c.tile;
    water_mark <= c.water;
    do @(posedge clk); while (!in_ready);
    pending_sprites.push_back(want);
    cells_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_sprites.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_MAP_WIDTH:   map_w_reg = val;
      REG_MAP_HEIGHT:  map_h_reg = val;
      REG_TILE_WIDTH:  tile_w_reg = val[8:0];
      REG_TILE_HEIGHT: tile_h_reg = val[8:0];
      REG_ATLAS_COLS:  cols_reg = val[8:0];
      REG_ATLAS_ROWS:  rows_reg = val[8:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [10:0] mw, logic [10:0] mh, logic [10:0] tw,
                            logic [10:0] th, logic [10:0] cols, logic [10:0] rows);
    drain_results();
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_MAP_HEIGHT, mh);
    write_reg(REG_TILE_WIDTH, tw);
    write_reg(REG_TILE_HEIGHT, th);
    write_reg(REG_ATLAS_COLS, cols);
    write_reg(REG_ATLAS_ROWS, rows);
    cfg_we <= 1'b0;
  endtask

  function automatic cell_t random_cell();
    cell_t c;
    int pick;
    int span;
    pick = $urandom_range(0, 9);
    span = (cols_reg * (rows_reg + 1) > 65535) ? 65535 : cols_reg * (rows_reg + 1);
    c.x = (pick < 3) ? 10'($urandom_range(0, 40)) : 10'($urandom);
    c.y = (pick > 6) ? 10'($urandom_range(0, 40)) : 10'($urandom);
    c.water = 1'($urandom_range(0, 1));
    if (pick == 0) c.tile = {1'b1, 16'($urandom)};
    else if (pick == 1) c.tile = 17'($urandom);
    else c.tile = 17'($urandom_range(0, span));
    return c;
  endfunction

  // directed cells: corners, tile extremes, empty cells, tile past the atlas
  cell_t edge_cells[12] = '{
    '{10'd0, 10'd0, 17'd0, 1'b1},
    '{10'd1023, 10'd1023, 17'd65535, 1'b1},
    '{10'd0, 10'd1023, -17'sd1, 1'b1},
    '{10'd1023, 10'd0, 17'h10000, 1'b1},
    '{10'd5, 10'd3, 17'd15, 1'b1},
    '{10'd3, 10'd5, 17'd14, 1'b0},
    '{10'd0, 10'd0, 17'd16, 1'b1},
    '{10'd512, 10'd512, 17'd65535, 1'b1},
    '{10'd10, 10'd10, -17'sd1, 1'b0},
    '{10'd1, 10'd0, 17'd1, 1'b1},
    '{10'd15, 10'd16, 17'd3, 1'b1},
    '{10'd682, 10'd341, 17'h15555, 1'b0}
  };

  initial begin
    sprite_t want;
    cell_t c;
    logic [10:0] rmw, rmh, rtw, rth, rc, rr;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the atlas is unusable: size, UVs and water read as zero
    foreach (edge_cells[i]) begin
      want = project_cell(edge_cells[i]);
      want.water = 1'b0;
      want.sw = '0;
      want.sh = '0;
      want.u = '0;
      want.v = '0;
      want.us = '0;
      want.vs = '0;
      if (i == 0) want.depth = 17'd65536;
      send_cell(edge_cells[i], want);
    end

    // same cells on a small 4x4 atlas
    load_setup(11'd16, 11'd16, 11'd64, 11'd32, 11'd4, 11'd4);
    foreach (edge_cells[i]) send_cell(edge_cells[i], project_cell(edge_cells[i]));

    // random phases over several register settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      rmw = 11'($urandom);
      rmh = 11'($urandom);
      rtw = 11'($urandom_range(0, 511));
      rth = 11'($urandom_range(0, 511));
      rc = 11'($urandom_range(0, 511));
      rr = 11'($urandom_range(0, 511));
      case (ph)
        0: load_setup(11'd16, 11'd16, 11'd64, 11'd32, 11'd8, 11'd8);
        1: load_setup(11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1);
        2: load_setup(11'd1024, 11'd1024, 11'd256, 11'd256, 11'd256, 11'd256);
        3: load_setup(11'd2047, 11'd0, 11'd511, 11'd0, 11'd511, 11'd3);
        4: load_setup(11'd0, 11'd2047, 11'd0, 11'd511, 11'd0, 11'd5);
        default: load_setup(rmw, rmh, rtw, rth, rc, rr);
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
        default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
      endcase
      for (int n = 0; n < 72; n++) begin
        // hold the sender off until the pipeline empties
        if (ph == 1 && n == 36) begin
          in_valid <= 1'b0;
          while (pending_sprites.size() != 0) @(posedge clk);
        end
        c = random_cell();
        send_cell(c, project_cell(c));
      end
    end

    drain_results();
    $display("Sent %0d map cells over 8 register settings and 4 idle patterns,",
             cells_sent);
    $display("checked %0d sprite instances field by field.", sprites_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* iso_tile_sprite_instance.f */
hw/rtl/itsi_pkg.sv
hw/rtl/itsi_div.sv
hw/rtl/iso_tile_sprite_instance.sv
tb/tb_iso_tile_sprite_instance.sv
